// ===== rtl/apnn_pkg.sv =====
package apnn_pkg;

  // Field widths of the request and result items.
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned SQ_DIST_W = 33;
  localparam int unsigned DIST_W    = 17;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [INDEX_W-1:0]   point_index;
    logic [SQ_DIST_W-1:0] min_sq_dist;
    logic [DIST_W-1:0]    nn_dist;
    logic                 no_neighbor;
    logic                 overflow;
    logic                 last_result;
  } result_t;

endpackage

// ===== rtl/apnn_ram.sv =====
module apnn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered and holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/all_pairs_nearest_neighbor_distance.sv =====
// All nearest neighbors of a 2-D point set, brute force.
//
// Requests: a request carries one point (x, y) and a last_point flag. It is taken
// at a rising edge where start is high and busy is low. Points are stored in
// load order; once MAX_POINTS are held, further points are dropped and the
// set is marked as overflowed. Busy stays low for a point that is not the last.
// The request with last_point set (stored or dropped) ends the set and raises
// busy. For each stored point, in load order, the block streams every stored
// point through one squaring multiplier (dx squared, then dy squared), keeps
// the smallest sum, then runs a bit-serial square root of one result bit per
// cycle.
// Results: one per stored point, each shown on result for exactly one cycle
// with result_valid high. The receiver cannot stall. busy falls in the cycle
// that shows the last result, so a new set can start right away.
// Reset (rst, synchronous) empties the set and stops any search in progress.
// The point memory itself is not cleared; only entries of the current set are read.
module all_pairs_nearest_neighbor_distance
  import apnn_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  point_t  point,
  output logic    busy,
  output logic    result_valid,
  output result_t result
);

  localparam int unsigned IW     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned MUL_W  = 2 * COORD_BITS;
  localparam int unsigned SQ_W   = 2 * COORD_BITS + 1;
  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned STEP_W = $clog2(ROOT_W);

  localparam logic [SQ_W-1:0] CMAX = SQ_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [SQ_W-1:0] SAT  = SQ_W'(CMAX * CMAX * SQ_W'(2));

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_GRAB  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;

  logic [2:0]            state;
  logic [CNT_W-1:0]      count;
  logic                  ovf;
  logic [IW-1:0]         i;
  logic [CNT_W-1:0]      j;
  logic                  ph;
  logic [COORD_BITS-1:0] xi;
  logic [COORD_BITS-1:0] yi;

  // Scan pipeline: valid, self-compare and end-of-row marks per stage.
  logic                  v1, v2, v3, v4;
  logic                  skip1, skip2, skip3, skip4;
  logic                  end1, end2, end3, end4;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [MUL_W-1:0]      mul_q;
  logic [MUL_W-1:0]      sq_x;
  logic [SQ_W-1:0]       best;
  logic                  found;

  // Square root unit.
  logic [RAD_W-1:0]      rad;
  logic [REM_W-1:0]      rem;
  logic [ROOT_W-1:0]     root;
  logic [STEP_W-1:0]     step;

  // Memory port signals.
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [MUL_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  logic [MUL_W-1:0]      ram_rdata;

  logic                  accept;
  logic                  issue;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic [COORD_BITS-1:0] xj;
  logic [COORD_BITS-1:0] yj;
  logic [COORD_BITS-1:0] mop;
  logic [SQ_W-1:0]       cand;
  logic                  take;
  logic [SQ_W-1:0]       best_next;
  logic                  found_next;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  root_bit;
  logic [REM_W-1:0]      rem_next;
  logic [ROOT_W-1:0]     root_next;
  logic                  row_last;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Only the low COORD_BITS bits of each coordinate take part.
  assign px = COORD_BITS'(point.point_x);
  assign py = COORD_BITS'(point.point_y);

  assign ram_we    = accept && (count < CNT_W'(MAX_POINTS));
  assign ram_waddr = count[IW-1:0];
  assign ram_wdata = {px, py};

  // A new neighbor read goes out while ph is low, until the row is done.
  assign issue     = (state == ST_SCAN) && !ph && (j < count);
  assign ram_re    = (state == ST_FETCH) || issue;
  assign ram_raddr = (state == ST_FETCH) ? i : j[IW-1:0];

  apnn_ram #(
    .WIDTH(MUL_W),
    .DEPTH(MAX_POINTS)
  ) u_point_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign xj = ram_rdata[MUL_W-1:COORD_BITS];
  assign yj = ram_rdata[COORD_BITS-1:0];

  // The one multiplier squares dx in the stage after the differences and dy
  // in the stage after that; reads go out only while ph is low, so they never clash.
  assign mop = v2 ? dx : dy;

  assign cand       = SQ_W'(sq_x) + SQ_W'(mul_q);
  assign take       = v4 && !skip4 && (!found || (cand < best));
  assign best_next  = take ? cand : best;
  assign found_next = found || take;

  // One result bit per cycle: bring down two radicand bits, try 4*root+1.
  assign rem_sh    = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign root_bit  = (rem_sh >= trial);
  assign rem_next  = root_bit ? (rem_sh - trial) : rem_sh;
  assign root_next = {root[ROOT_W-2:0], root_bit};

  assign row_last = (CNT_W'(i) == (count - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      ovf          <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      // Scan pipeline stages shift every cycle.
      v1    <= issue;
      skip1 <= (j[IW-1:0] == i);
      end1  <= (j == (count - CNT_W'(1)));
      v2    <= v1;
      skip2 <= skip1;
      end2  <= end1;
      v3    <= v2;
      skip3 <= skip2;
      end3  <= end2;
      v4    <= v3;
      skip4 <= skip3;
      end4  <= end3;
      if (v1) begin
        dx <= (xi > xj) ? (xi - xj) : (xj - xi);
        dy <= (yi > yj) ? (yi - yj) : (yj - yi);
      end
      mul_q <= MUL_W'(mop) * MUL_W'(mop);
      if (v3) begin
        sq_x <= mul_q;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count < CNT_W'(MAX_POINTS)) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (point.last_point) begin
              i     <= '0;
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_GRAB;
        end
        ST_GRAB: begin
          xi    <= xj;
          yi    <= yj;
          j     <= '0;
          ph    <= 1'b0;
          best  <= SAT;
          found <= 1'b0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          ph    <= !ph;
          best  <= best_next;
          found <= found_next;
          if (issue) begin
            j <= j + CNT_W'(1);
          end
          if (v4 && end4) begin
            rad   <= RAD_W'(best_next);
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          rem  <= rem_next;
          root <= root_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(ROOT_W - 1)) begin
            result_valid       <= 1'b1;
            result.point_index <= INDEX_W'(i);
            result.min_sq_dist <= SQ_DIST_W'(best);
            result.nn_dist     <= DIST_W'(root_next);
            result.no_neighbor <= !found;
            result.overflow    <= ovf;
            result.last_result <= row_last;
            if (row_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= ST_IDLE;
            end else begin
              i     <= i + IW'(1);
              state <= ST_FETCH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
